[rtl/mms_pkg.sv]
// Shared types and constants for the min-max feature scaler.
package mms_pkg;

   localparam int VALUE_BITS   = 32;
   localparam int MAX_FEATURES = 64;
   localparam int INDEX_BITS   = 6;
   localparam int COUNT_BITS   = 7;
   localparam int FRAC_SHIFT   = 15;
   localparam int NUM_BITS     = VALUE_BITS + FRAC_SHIFT;
   localparam int STEP_BITS    = $clog2(NUM_BITS + 1);

   localparam logic [COUNT_BITS-1:0] FEATURES_RESET = COUNT_BITS'(MAX_FEATURES);

   localparam logic [VALUE_BITS-1:0] MIN_RESET = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] MAX_RESET = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] MINUS_ONE = VALUE_BITS'(-16384);
   localparam logic [VALUE_BITS-1:0] PLUS_ONE  = VALUE_BITS'(16384);

   localparam logic [1:0] MODE_LEARN = 2'd0;
   localparam logic [1:0] MODE_SCALE = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_FETCH  = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_FIX    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [NUM_BITS-1:0]   numerator;
      logic [VALUE_BITS-1:0] denominator;
   } div_request_type;

   typedef struct packed {
      logic                done;
      logic [NUM_BITS-1:0] quotient;
   } div_result_type;

endpackage

[rtl/mms_ram.sv]
// Generic single-port-write, registered-read RAM.
module mms_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mms_div.sv]
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
module mms_div (
   input  logic                     clock,
   input  logic                     reset,
   input  mms_pkg::div_request_type req,
   output mms_pkg::div_result_type  res
);

   logic [mms_pkg::VALUE_BITS-1:0] rem_ff, rem_in;
   logic [mms_pkg::NUM_BITS-1:0]   quo_ff, quo_in;
   logic [mms_pkg::VALUE_BITS-1:0] den_ff, den_in;
   logic [mms_pkg::STEP_BITS-1:0]  count_ff, count_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [mms_pkg::VALUE_BITS+1:0] trial;

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {1'b0, rem_ff, quo_ff[mms_pkg::NUM_BITS-1]} - {2'b00, den_ff};
      if (req.start) begin
         rem_in   = '0;
         quo_in   = req.numerator;
         den_in   = req.denominator;
         count_in = mms_pkg::STEP_BITS'(mms_pkg::NUM_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[mms_pkg::VALUE_BITS+1]) begin
            rem_in = trial[mms_pkg::VALUE_BITS-1:0];
            quo_in = {quo_ff[mms_pkg::NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[mms_pkg::VALUE_BITS-2:0], quo_ff[mms_pkg::NUM_BITS-1]};
            quo_in = {quo_ff[mms_pkg::NUM_BITS-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == mms_pkg::STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      count_ff <= count_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule

[rtl/min_max_feature_scaler.sv]
// Min-max feature scaler top level: sequencer, statistics store and result register.
//
// Requests arrive on req_valid/req_ready with a mode, a feature index and a
// signed Q16.16 sample. Learn folds the sample into that feature's minimum and
// maximum; clear forgets all statistics at once; scale returns one response on
// rsp_valid/rsp_ready with a Q2.14 value, in [-1, +1] for a sample within the
// learned range, or the sample unchanged with rsp_kept_original set when the
// feature is unused or has min equal to max. csr_wr_en/csr_wr_data set the
// number of features in use (reset 64). One request is worked on at a time;
// req_ready is low while it is in flight. Clear and ignored requests finish on
// acceptance; learn reads the statistics, then writes them back. Scale adds
// divide and fix when a division is needed: the 47-bit quotient comes from the
// radix-2 divider at one bit per cycle. A response sits in an output register;
// the next request is accepted while it waits, and a later scale holds before
// its response until rsp_ready frees that register. Reset makes every feature
// unlearned, sets the feature count to 64 and empties the response register.
module min_max_feature_scaler (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_mode,
   input  logic [mms_pkg::INDEX_BITS-1:0]        req_feature_index,
   input  logic signed [mms_pkg::VALUE_BITS-1:0] req_sample_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mms_pkg::VALUE_BITS-1:0] rsp_scaled_value,
   output logic                                  rsp_kept_original,
   output logic [mms_pkg::INDEX_BITS-1:0]        rsp_echo_index,
   input  logic                                  csr_wr_en,
   input  logic [mms_pkg::COUNT_BITS-1:0]        csr_wr_data
);

   localparam int VB = mms_pkg::VALUE_BITS;
   localparam int QB = mms_pkg::NUM_BITS + 1;
   localparam int RB = mms_pkg::NUM_BITS + 2;

   mms_pkg::state_type              state_ff, state_in;
   logic [1:0]                      mode_ff, mode_in;
   logic [mms_pkg::INDEX_BITS-1:0]  idx_ff, idx_in;
   logic [VB-1:0]                   value_ff, value_in;
   logic                            neg_ff, neg_in;
   logic [VB-1:0]                   res_ff, res_in;
   logic                            kept_ff, kept_in;
   logic [mms_pkg::COUNT_BITS-1:0]  fiu_ff, fiu_in;
   logic [mms_pkg::MAX_FEATURES-1:0] seen_ff, seen_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [VB-1:0]                   rsp_value_ff, rsp_value_in;
   logic                            rsp_kept_ff, rsp_kept_in;
   logic [mms_pkg::INDEX_BITS-1:0]  rsp_index_ff, rsp_index_in;

   logic                            accept;
   logic                            in_use;
   logic                            ram_wr_en;
   logic [mms_pkg::INDEX_BITS-1:0]  ram_rd_addr;
   logic [2*VB-1:0]                 ram_wr_data;
   logic [2*VB-1:0]                 ram_rd_data;
   logic signed [VB-1:0]            lo, hi, v;
   logic signed [VB:0]              diff_num, diff_den;
   logic [VB:0]                     mag_num, mag_den;
   logic signed [QB-1:0]            q_signed;
   logic signed [RB-1:0]            r_full;
   mms_pkg::div_request_type        div_req;
   mms_pkg::div_result_type         div_res;

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == mms_pkg::ST_IDLE);
   assign ram_rd_addr = (state_ff == mms_pkg::ST_IDLE) ? req_feature_index : idx_ff;
   assign in_use      = ({1'b0, idx_ff} < fiu_ff);

   assign v  = value_ff;
   assign lo = seen_ff[idx_ff] ? ram_rd_data[VB-1:0]    : mms_pkg::MIN_RESET;
   assign hi = seen_ff[idx_ff] ? ram_rd_data[2*VB-1:VB] : mms_pkg::MAX_RESET;

   assign diff_num = {v[VB-1], v} - {lo[VB-1], lo};
   assign diff_den = {hi[VB-1], hi} - {lo[VB-1], lo};
   assign mag_num  = diff_num[VB] ? (~diff_num + 1'b1) : diff_num;
   assign mag_den  = diff_den[VB] ? (~diff_den + 1'b1) : diff_den;

   assign ram_wr_data = {((v > hi) ? v : hi), ((v < lo) ? v : lo)};
   assign ram_wr_en   = (state_ff == mms_pkg::ST_FETCH) && (mode_ff == mms_pkg::MODE_LEARN)
                        && in_use;

   assign q_signed = neg_ff ? -$signed({1'b0, div_res.quotient})
                            : $signed({1'b0, div_res.quotient});
   assign r_full   = $signed({q_signed[QB-1], q_signed}) - RB'(16384);

   always_comb begin
      div_req.start       = 1'b0;
      div_req.numerator   = {mag_num[VB-1:0], {mms_pkg::FRAC_SHIFT{1'b0}}};
      div_req.denominator = mag_den[VB-1:0];

      state_in     = state_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      kept_in      = kept_ff;
      fiu_in       = fiu_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_kept_in  = rsp_kept_ff;
      rsp_index_in = rsp_index_ff;

      if (csr_wr_en) begin
         fiu_in = csr_wr_data;
      end

      case (state_ff)
         mms_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               idx_in   = req_feature_index;
               value_in = req_sample_value;
               if (req_mode == mms_pkg::MODE_CLEAR) begin
                  seen_in = '0;
               end else if (req_mode == mms_pkg::MODE_LEARN ||
                            req_mode == mms_pkg::MODE_SCALE) begin
                  state_in = mms_pkg::ST_FETCH;
               end
            end
         end
         mms_pkg::ST_FETCH: begin
            if (mode_ff == mms_pkg::MODE_LEARN) begin
               if (in_use) begin
                  seen_in[idx_ff] = 1'b1;
               end
               state_in = mms_pkg::ST_IDLE;
            end else if (!in_use || lo == hi) begin
               res_in   = value_ff;
               kept_in  = 1'b1;
               state_in = mms_pkg::ST_FINISH;
            end else if (v == lo) begin
               res_in   = mms_pkg::MINUS_ONE;
               kept_in  = 1'b0;
               state_in = mms_pkg::ST_FINISH;
            end else if (v == hi) begin
               res_in   = mms_pkg::PLUS_ONE;
               kept_in  = 1'b0;
               state_in = mms_pkg::ST_FINISH;
            end else begin
               div_req.start = 1'b1;
               neg_in        = diff_num[VB] ^ diff_den[VB];
               kept_in       = 1'b0;
               state_in      = mms_pkg::ST_DIVIDE;
            end
         end
         mms_pkg::ST_DIVIDE: begin
            if (div_res.done) begin
               state_in = mms_pkg::ST_FIX;
            end
         end
         mms_pkg::ST_FIX: begin
            if (r_full > $signed(RB'(mms_pkg::MIN_RESET))) begin
               res_in = mms_pkg::MIN_RESET;
            end else if (r_full < -$signed(RB'(mms_pkg::MAX_RESET))) begin
               res_in = mms_pkg::MAX_RESET;
            end else begin
               res_in = r_full[VB-1:0];
            end
            state_in = mms_pkg::ST_FINISH;
         end
         mms_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_kept_in  = kept_ff;
               rsp_index_in = idx_ff;
               state_in     = mms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mms_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mms_pkg::ST_IDLE;
         fiu_ff       <= mms_pkg::FEATURES_RESET;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fiu_ff       <= fiu_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      idx_ff       <= idx_in;
      value_ff     <= value_in;
      neg_ff       <= neg_in;
      res_ff       <= res_in;
      kept_ff      <= kept_in;
      rsp_value_ff <= rsp_value_in;
      rsp_kept_ff  <= rsp_kept_in;
      rsp_index_ff <= rsp_index_in;
   end

   mms_ram #(
      .WIDTH (2 * mms_pkg::VALUE_BITS),
      .DEPTH (mms_pkg::MAX_FEATURES)
   ) u_stats (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mms_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .res   (div_res)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scaled_value  = rsp_value_ff;
   assign rsp_kept_original = rsp_kept_ff;
   assign rsp_echo_index    = rsp_index_ff;

endmodule
